FILE: design/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, sizes and helpers for the LIFO stack with usage counters.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WORD_W      = 32;
  localparam int FILL_W      = 9;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    status_t                  status;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic [WORD_W-1:0]        push_total;
    logic [WORD_W-1:0]        pop_total;
    logic [FILL_W-1:0]        peak_fill;
  } res_t;

  // Low FILL_W bits of a fill count, zero-extended when the count is narrower.
  function automatic logic [FILL_W-1:0] fill_bits(input cnt_t c);
    logic [CNT_W+FILL_W-1:0] ext;
    ext = {{FILL_W{1'b0}}, c};
    return ext[FILL_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

FILE: design/lifo_stack_with_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_stats
// LIFO store of 32-bit words with push/pop/peek and usage counters.
// out_tvalid rises after the result is registered in lss_ctrl and again in the output register.
// Throughput: one transfer per cycle while out_tready stays high; the top
// entry is read through the stack RAM's registered read port.
// Reset clears fill count, counters and peak; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_stats (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // mode[1:0], push_value[33:2], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // read_value[31:0], status[33:32],
                                   // fill_count[42:34], is_empty[43],
                                   // push_total[75:44], pop_total[107:76],
                                   // peak_fill[116:108], zero pad
);

  import lss_pkg::*;

  logic          res_valid, res_ready;
  res_t          res;
  logic          out_tvalid_r;
  logic [119:0]  out_tdata_r;

  assign res_ready = !out_tvalid_r || out_tready;

  lss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mode       (in_tdata[1:0]),
    .push_value (in_tdata[33:2]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {3'b000, res.peak_fill, res.pop_total, res.push_total,
                      res.is_empty, res.fill_count, res.status, res.read_value};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[43] == (out_tdata[42:34] == '0)))
    else $error("is_empty disagrees with fill_count");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[116:108] >= out_tdata[42:34]))
    else $error("peak_fill below fill_count");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == STAT_EMPTY)
      |-> (out_tdata[31:0] == '1 && out_tdata[43]))
    else $error("empty status without empty answer");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == STAT_FULL)
      |-> (out_tdata[42:34] == fill_bits(cnt_t'(STACK_DEPTH)) && out_tdata[31:0] == '0))
    else $error("full status with store not full");

endmodule

FILE: design/lss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/lss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// Stack pointer, counters and memory sequencing. Holds one result until taken.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [lss_pkg::WORD_W-1:0]  push_value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output lss_pkg::res_t               res
);

  import lss_pkg::*;

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  state_t            state_r, state_nxt;
  cnt_t              count_r, count_nxt;
  logic [WORD_W-1:0] push_cnt_r, push_cnt_nxt;
  logic [WORD_W-1:0] pop_cnt_r, pop_cnt_nxt;
  cnt_t              peak_r, peak_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  status_t           status_r, status_nxt;
  logic              use_mem_r, use_mem_nxt;

  logic              in_xfer;
  logic              full, empty;
  cnt_t              count_inc, count_dec;
  logic              wr_en, rd_en;
  logic [WORD_W-1:0] rd_data;

  assign full      = (count_r == cnt_t'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  assign in_ready  = (state_r == ST_IDLE) || res_ready;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    push_cnt_nxt = push_cnt_r;
    pop_cnt_nxt  = pop_cnt_r;
    peak_nxt     = peak_r;
    rd_nxt       = rd_r;
    status_nxt   = status_r;
    use_mem_nxt  = use_mem_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;

    if (state_r == ST_BUSY && res_ready) begin
      state_nxt = ST_IDLE;
    end

    if (in_xfer) begin
      state_nxt   = ST_BUSY;
      use_mem_nxt = 1'b0;
      status_nxt  = STAT_DONE;
      rd_nxt      = '0;
      if (mode == MODE_PUSH) begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en        = 1'b1;
          count_nxt    = count_inc;
          push_cnt_nxt = sat_inc(push_cnt_r);
          if (count_inc > peak_r) begin
            peak_nxt = count_inc;
          end
        end
      end else begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
          rd_nxt     = '1;
        end else begin
          rd_en       = 1'b1;
          use_mem_nxt = 1'b1;
          if (mode == MODE_POP) begin
            count_nxt   = count_dec;
            pop_cnt_nxt = sat_inc(pop_cnt_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      push_cnt_r <= '0;
      pop_cnt_r  <= '0;
      peak_r     <= '0;
      use_mem_r  <= 1'b0;
      status_r   <= STAT_DONE;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      push_cnt_r <= push_cnt_nxt;
      pop_cnt_r  <= pop_cnt_nxt;
      peak_r     <= peak_nxt;
      use_mem_r  <= use_mem_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
  end

  lss_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (count_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // counters already hold post-operation values until the next transfer
  assign res_valid       = (state_r == ST_BUSY);
  assign res.read_value  = use_mem_r ? rd_data : rd_r;
  assign res.status      = status_r;
  assign res.fill_count  = fill_bits(count_r);
  assign res.is_empty    = empty;
  assign res.push_total  = push_cnt_r;
  assign res.pop_total   = pop_cnt_r;
  assign res.peak_fill   = fill_bits(peak_r);

endmodule

FILE: tb/tb_lifo_stack_with_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_stats
// Self-checking bench for the LIFO stack with usage counters. Push, pop and
// peek transfers go in on in_, with random bursts of idle on both sides. A
// scoreboard keeps its own copy of the stack and counters, and checks every
// out_ transfer field by field, in order. Covers the empty and full cases, the
// spare mode code, one complete fill to capacity and a complete drain.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_stats;
  import lss_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int ITEM_TARGET    = 1850;
  localparam int QUIET_TAIL     = 250;
  localparam int WATCHDOG_LIMIT = 4000;

  class stack_scoreboard;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int unsigned       depth;
    int unsigned       peak;
    logic [WORD_W-1:0] pushes;
    logic [WORD_W-1:0] pops;
    res_t              awaited [$];
    int                errors;
    int                checked;

    function new();
      depth   = 0;
      peak    = 0;
      pushes  = '0;
      pops    = '0;
      errors  = 0;
      checked = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] result %0d: %s", $time, checked, msg);
    endtask

    task note_op(logic [1:0] m, logic [WORD_W-1:0] v);
      res_t r;
      r = '0;
      r.status = STAT_DONE;
      if (m == MODE_PUSH) begin
        if (depth >= STACK_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          words[depth] = v;
          depth++;
          if (!(&pushes)) pushes++;
          if (depth > peak) peak = depth;
        end
      end else if (depth == 0) begin
        // pop, peek and the spare code all answer -1 when empty
        r.read_value = '1;
        r.status     = STAT_EMPTY;
      end else begin
        r.read_value = words[depth-1];
        if (m == MODE_POP) begin
          depth--;
          if (!(&pops)) pops++;
        end
      end
      r.fill_count = depth[FILL_W-1:0];
      r.is_empty   = (depth == 0);
      r.push_total = pushes;
      r.pop_total  = pops;
      r.peak_fill  = peak[FILL_W-1:0];
      awaited.push_back(r);
    endtask

    task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(logic [119:0] d);
      res_t e;
      if (awaited.size() == 0) begin
        report_mismatch("transfer with no result awaited");
        return;
      end
      e = awaited.pop_front();
      compare_field("read_value", d[31:0], e.read_value);
      compare_field("status", d[33:32], e.status);
      compare_field("fill_count", d[42:34], e.fill_count);
      compare_field("is_empty", d[43], e.is_empty);
      compare_field("push_total", d[75:44], e.push_total);
      compare_field("pop_total", d[107:76], e.pop_total);
      compare_field("peak_fill", d[116:108], e.peak_fill);
      checked++;
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;   // mode[1:0], push_value[33:2], zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;  // read_value, status, fill_count, is_empty,
                            // push_total, pop_total, peak_fill, zero pad

  stack_scoreboard sb = new();
  int  sent;
  int  gap_odds;
  bit  quiet;
  int  idle_cycles;

  lifo_stack_with_stats dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lifo_stack_with_stats NOT OK");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the transfer and any idle gap
  task send_op(logic [1:0] m, logic [WORD_W-1:0] v);
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, v, m};
    do @(posedge clk); while (!in_tready);
    sb.note_op(m, v);
    sent++;
    if (sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
    @(negedge clk);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task random_op(int unsigned push_pct);
    int unsigned roll;
    logic [1:0]  m;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      m = MODE_PUSH;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 7) m = MODE_POP;
      else if (roll < 9) m = MODE_PEEK;
      else m = MODE_SPARE;
    end
    send_op(m, pick_word());
  endtask

  initial begin
    int unsigned seg_len;
    int unsigned push_pct;
    bit          filled;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    sent        = 0;
    gap_odds    = 4;
    quiet       = 1'b0;
    idle_cycles = 0;
    filled      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty store, every read-type code
    send_op(MODE_POP, $urandom);
    send_op(MODE_PEEK, $urandom);
    send_op(MODE_SPARE, $urandom);
    // extreme words
    send_op(MODE_PUSH, 32'h7FFF_FFFF);
    send_op(MODE_PUSH, 32'h8000_0000);
    send_op(MODE_PUSH, '0);
    send_op(MODE_PUSH, '1);
    send_op(MODE_PUSH, 32'hAAAA_AAAA);
    send_op(MODE_PUSH, 32'h5555_5555);
    send_op(MODE_PEEK, $urandom);
    send_op(MODE_SPARE, $urandom);
    send_op(MODE_POP, $urandom);
    send_op(MODE_POP, $urandom);
    send_op(MODE_PEEK, '1);
    repeat (4) send_op(MODE_POP, $urandom);
    send_op(MODE_POP, '0);
    send_op(MODE_PEEK, $urandom);
    wait_drained();

    while (sent < ITEM_TARGET) begin
      if (!filled && sent > 500) begin
        // run up to capacity, push past it, then empty completely
        filled = 1'b1;
        while (sb.depth < STACK_DEPTH) begin
          if ($urandom_range(0, 9) == 0) send_op(MODE_PEEK, $urandom);
          else send_op(MODE_PUSH, pick_word());
        end
        repeat (3) send_op(MODE_PUSH, pick_word());
        send_op(MODE_SPARE, $urandom);
        while (sb.depth > 0) send_op(MODE_POP, $urandom);
        repeat (2) send_op(MODE_POP, $urandom);
        wait_drained();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_pct = 80;
        4, 5, 6:    push_pct = 25;
        default:    push_pct = 50;
      endcase
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
      seg_len  = $urandom_range(10, 120);
      repeat (seg_len) random_op(push_pct);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_lifo_stack_with_stats OK");
    end else begin
      $display("tb_lifo_stack_with_stats NOT OK");
    end
    $finish;
  end

endmodule
